### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the key/value table.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define OKVT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Consequence must hold in the same cycle as the antecedent.
`define OKVT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define OKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/okvt_pkg.sv
// Package for the ordered key/value table: codes, word types and control structs.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

   // Default number of table entries.
   localparam int unsigned OKVT_DEPTH = 16;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_GET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } okvt_op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_EXISTING  = 2'd0,
      ST_INSERTED  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } okvt_status_type;

   // Request word.
   typedef struct packed {
      okvt_op_type operation;
      logic [31:0] key;
      logic [31:0] write_value;
   } okvt_req_type;

   // Result word.
   typedef struct packed {
      okvt_status_type status;
      logic [31:0]     read_value;
      logic [3:0]      position;
      logic [4:0]      entry_count;
   } okvt_rsp_type;

   // Control broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      okvt_op_type op;
      logic        compare;
      logic        commit;
      logic        found;
   } okvt_cmd_type;

   // Sequencer states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } okvt_state_type;

endpackage

`default_nettype wire

### rtl/core/okvt_cell.sv
// One entry of the key/value chain: stores a key and a value, compares the probe
// key and takes its right neighbor's entry when a delete closes a gap. Uses okvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module okvt_cell import okvt_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = OKVT_DEPTH,
   parameter int unsigned INDEX       = 0,
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1),
   localparam int unsigned PW = $clog2(TABLE_DEPTH)
) (
   input  wire logic          clock,
   input  wire okvt_cmd_type  cmd,
   input  wire logic [CW-1:0] count,
   input  wire logic [PW-1:0] pos,
   input  wire logic [31:0]   probe_key,
   input  wire logic [31:0]   write_key,
   input  wire logic [31:0]   write_value,
   input  wire logic [31:0]   right_key,
   input  wire logic [31:0]   right_value,
   output logic [31:0]        key_ff,
   output logic [31:0]        value_ff,
   output logic               hit_ff
);

   localparam logic [CW-1:0] MY_COUNT_INDEX = CW'(INDEX);
   localparam logic [PW-1:0] MY_POS_INDEX   = PW'(INDEX);

   logic [31:0] key_in;
   logic [31:0] value_in;
   logic        hit_in;
   logic        occupied;

   // The entry holds live data only below the fill count.
   assign occupied = (MY_COUNT_INDEX < count);

   // Capture the match when a request arrives; hold it until the request retires.
   always_comb begin
      hit_in = hit_ff;
      if (cmd.compare) begin
         hit_in = occupied && (key_ff == probe_key);
      end
   end

   // Entry update: overwrite on a set hit, append at the fill point, shift on delete.
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.commit) begin
         case (cmd.op)
            OP_SET: begin
               if (cmd.found) begin
                  if (hit_ff) begin
                     value_in = write_value;
                  end
               end else if (count == MY_COUNT_INDEX) begin
                  key_in   = write_key;
                  value_in = write_value;
               end
            end
            OP_DELETE: begin
               if (cmd.found && (MY_POS_INDEX >= pos)) begin
                  key_in   = right_key;
                  value_in = right_value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

endmodule

`default_nettype wire

### rtl/core/okvt_match_encode.sv
// Turns the chain's one-hot match vector into a found flag, a position and the
// matching value. Uses okvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module okvt_match_encode import okvt_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = OKVT_DEPTH,
   localparam int unsigned PW = $clog2(TABLE_DEPTH)
) (
   input  wire logic [TABLE_DEPTH-1:0]       hit_vec,
   input  wire logic [TABLE_DEPTH-1:0][31:0] values,
   output logic                              found,
   output logic [PW-1:0]                     pos,
   output logic [31:0]                       value
);

   // Keys are unique among live entries, so at most one bit is set and an OR
   // over the masked indexes and values selects the match.
   always_comb begin
      pos   = '0;
      value = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (hit_vec[i]) begin
            pos   = pos | PW'(i);
            value = value | values[i];
         end
      end
      found = |hit_vec;
   end

endmodule

`default_nettype wire

### rtl/core/ordered_key_value_table.sv
// Ordered key/value table. Entries are kept in insertion order in a chain of
// TABLE_DEPTH cells. In the cycle a request (set, get, delete, clear) is
// accepted every cell compares its key with the request key and registers the
// match; in the execute state that follows, the match is encoded, the result
// word is loaded into the output register and the chain is updated (a delete
// shifts every later cell down by one at once). The request channel stalls in
// the execute state, which lasts as long as the previous result is still held
// in the output register by rsp_stall, so one request is in flight beside at
// most one waiting result. Position and entry count are reported masked to 4 and 5 bits.
// Depends on okvt_pkg, okvt_cell, okvt_match_encode and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ordered_key_value_table import okvt_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = OKVT_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  wire okvt_req_type req_data,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output okvt_rsp_type rsp_data
);

   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned PW = $clog2(TABLE_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   okvt_state_type state_ff;
   okvt_state_type state_in;

   okvt_req_type req_ff;
   okvt_req_type req_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   okvt_rsp_type  rsp_ff;
   okvt_rsp_type  rsp_in;

   logic          accept;
   logic          commit;
   okvt_cmd_type  cmd;

   logic [TABLE_DEPTH-1:0]       hit_vec;
   logic [TABLE_DEPTH-1:0][31:0] key_vec;
   logic [TABLE_DEPTH-1:0][31:0] value_vec;
   logic                         found;
   logic [PW-1:0]                match_pos;
   logic [31:0]                  match_value;

   logic [31:0] pos_wide;
   logic [31:0] count_wide;

   // Handshake events.
   assign accept = req_valid && !req_stall;
   assign commit = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      unique case (state_ff)
         S_IDLE:  req_stall = 1'b0;
         S_EXEC:  req_stall = 1'b1;
         default: req_stall = 1'b1;
      endcase
   end

   // Broadcast control for the chain.
   always_comb begin
      cmd.op      = req_ff.operation;
      cmd.compare = accept;
      cmd.commit  = commit;
      cmd.found   = found;
   end

   // Chain of entry cells; the last cell has no right neighbor and keeps its own.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [31:0] right_key;
      logic [31:0] right_value;

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_key   = key_vec[i];
         assign right_value = value_vec[i];
      end else begin : g_inner
         assign right_key   = key_vec[i + 1];
         assign right_value = value_vec[i + 1];
      end

      okvt_cell #(
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .pos         (match_pos),
         .probe_key   (req_data.key),
         .write_key   (req_ff.key),
         .write_value (req_ff.write_value),
         .right_key   (right_key),
         .right_value (right_value),
         .key_ff      (key_vec[i]),
         .value_ff    (value_vec[i]),
         .hit_ff      (hit_vec[i])
      );
   end

   okvt_match_encode #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_encode (
      .hit_vec (hit_vec),
      .values  (value_vec),
      .found   (found),
      .pos     (match_pos),
      .value   (match_value)
   );

   // Request capture.
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in = req_data;
      end
   end

   // Result word and new fill count.
   always_comb begin
      count_in            = count_ff;
      pos_wide            = '0;
      rsp_in              = rsp_ff;
      rsp_in.status       = ST_NOT_FOUND;
      rsp_in.read_value   = '0;
      unique case (req_ff.operation)
         OP_CLEAR: begin
            rsp_in.status = ST_INSERTED;
            count_in      = '0;
         end
         OP_SET: begin
            if (found) begin
               rsp_in.status = ST_EXISTING;
               pos_wide      = 32'(match_pos);
            end else if (count_ff != FULL_COUNT) begin
               rsp_in.status = ST_INSERTED;
               pos_wide      = 32'(count_ff);
               count_in      = count_ff + CW'(1);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_GET: begin
            if (found) begin
               rsp_in.status     = ST_EXISTING;
               rsp_in.read_value = match_value;
               pos_wide          = 32'(match_pos);
            end
         end
         OP_DELETE: begin
            if (found) begin
               rsp_in.status = ST_EXISTING;
               pos_wide      = 32'(match_pos);
               count_in      = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase
      count_wide         = 32'(count_in);
      rsp_in.position    = pos_wide[3:0];
      rsp_in.entry_count = count_wide[4:0];
      if (!commit) begin
         count_in = count_ff;
         rsp_in   = rsp_ff;
      end
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the table's own bookkeeping.
   `OKVT_ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= FULL_COUNT)
   `OKVT_ASSERT_IMPLIES(a_unique_match, clock, reset, state_ff == S_EXEC, $onehot0(hit_vec))
   `OKVT_ASSERT_NEXT(a_commit_loads_rsp, clock, reset, commit, rsp_valid_ff)
   `OKVT_ASSERT_NEXT(a_clear_empties, clock, reset, commit && req_ff.operation == OP_CLEAR, count_ff == '0)

endmodule

`default_nettype wire
